// ----- src/insert_size_histogram_peak_core_defines.svh -----
`ifndef INSERT_SIZE_HISTOGRAM_PEAK_CORE_DEFINES_SVH
`define INSERT_SIZE_HISTOGRAM_PEAK_CORE_DEFINES_SVH

// next-cycle implication, off while reset is asserted
`define ISHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ishp: next-cycle check failed");

// next-cycle implication, also checked through reset
`define ISHP_ASSERT_NEXT_NORST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ishp: reset check failed");

`endif

// ----- src/ishp_pkg.sv -----
package ishp_pkg;

    localparam int HIST_BINS_DEF  = 1024;
    localparam int COUNT_BITS_DEF = 32;

    localparam int BIN_W   = 10;
    localparam int BIN_MAX = 1023;
    localparam int SIZE_W  = 14;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef logic [BIN_W-1:0]     bin_t;
    typedef logic [SIZE_W-1:0]    size_val_t;
    typedef logic [OUT_CNT_W-1:0] out_cnt_t;

    localparam bin_t LIMIT_RESET = bin_t'(512);

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_PEAK   = 1'b1;

    typedef struct packed {
        logic overlapped;
        logic offset_positive;
        bin_t overlap_length;
        bin_t first_read_length;
        bin_t second_read_length;
        bin_t first_front_trim;
        bin_t second_front_trim;
    } rec_t;

    typedef struct packed {
        logic answer_kind;
        bin_t bin_index;
    } result_t;

endpackage

// ----- src/ishp_ram.sv -----
module ishp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/ishp_bin_calc.sv -----
module ishp_bin_calc (
    input  ishp_pkg::rec_t rec,
    input  ishp_pkg::bin_t eff_lim,
    output ishp_pkg::bin_t bin
);

    ishp_pkg::size_val_t pos_sum;
    ishp_pkg::size_val_t ovl_sum;
    ishp_pkg::size_val_t lim_ext;
    logic signed [ishp_pkg::SIZE_W-1:0] size;

    always_comb begin
        pos_sum = ishp_pkg::size_val_t'(rec.first_read_length)
                + ishp_pkg::size_val_t'(rec.second_read_length)
                + ishp_pkg::size_val_t'(rec.first_front_trim)
                + ishp_pkg::size_val_t'(rec.second_front_trim);
        ovl_sum = ishp_pkg::size_val_t'(rec.overlap_length)
                + ishp_pkg::size_val_t'(rec.first_front_trim)
                + ishp_pkg::size_val_t'(rec.second_front_trim);
        lim_ext = ishp_pkg::size_val_t'(eff_lim);

        if (rec.overlapped && rec.offset_positive) begin
            size = $signed(pos_sum - ishp_pkg::size_val_t'(rec.overlap_length));
        end else if (rec.overlapped) begin
            size = $signed(ovl_sum);
        end else begin
            size = $signed(lim_ext);
        end

        if (size < 0) begin
            bin = '0;
        end else if (size > $signed(lim_ext)) begin
            bin = eff_lim;
        end else begin
            bin = size[ishp_pkg::BIN_W-1:0];
        end
    end

endmodule

// ----- src/ishp_out_fifo.sv -----
module ishp_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ishp_pkg::result_t   push_data,
    input  logic                pop,
    output logic                out_valid,
    output ishp_pkg::result_t   out_data,
    output ishp_pkg::out_cnt_t  count
);

    ishp_pkg::result_t                 mem [ishp_pkg::OUT_DEPTH];
    logic [ishp_pkg::OUT_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ishp_pkg::OUT_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    ishp_pkg::out_cnt_t                cnt_reg, cnt_next;
    logic                              do_pop;

    always_comb begin
        do_pop      = pop && (cnt_reg != '0);
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign count     = cnt_reg;

endmodule

// ----- src/insert_size_histogram_peak_core.sv -----
// channel   | handshake          | payload
// s_ (in)   | s_valid / s_ready  | opcode, overlap result, read lengths, front trims
// m_ (out)  | m_valid / m_ready  | answer_kind, bin_index
// cfg       | cfg_wr_en          | cfg_wr_data (insert_size_limit)
//
// Record: one item per cycle while s_ready is high, read-modify-write of the bin counter
//   in block RAM, result queued from the s2 register, after the s1 register; a write-to-read
//   bypass covers back-to-back hits on one bin.
// Query: pipeline drain, then one RAM read per bin below the limit, then the peak
//   result is queued; no items accepted meanwhile.
// Reset: a clearing pass writes zero to all HIST_BINS entries, one per cycle, with
//   s_ready low; config writes are taken during the pass.
// Stalls: a 4-entry result queue; s_ready drops when queued plus in-flight items reach 4.
module insert_size_histogram_peak_core #(
    parameter int HIST_BINS  = ishp_pkg::HIST_BINS_DEF,
    parameter int COUNT_BITS = ishp_pkg::COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  ishp_pkg::bin_t       cfg_wr_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic                 s_overlapped,
    input  logic                 s_offset_positive,
    input  ishp_pkg::bin_t       s_overlap_length,
    input  ishp_pkg::bin_t       s_first_read_length,
    input  ishp_pkg::bin_t       s_second_read_length,
    input  ishp_pkg::bin_t       s_first_front_trim,
    input  ishp_pkg::bin_t       s_second_front_trim,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_answer_kind,
    output ishp_pkg::bin_t       m_bin_index
);

    localparam int ADDR_W  = $clog2(HIST_BINS);
    localparam int LIM_CAP = (HIST_BINS - 1 > ishp_pkg::BIN_MAX) ? ishp_pkg::BIN_MAX
                                                                 : HIST_BINS - 1;

    typedef logic [ADDR_W-1:0]              addr_t;
    typedef logic [COUNT_BITS-1:0]          count_t;
    typedef logic [ishp_pkg::OUT_CNT_W:0]   occ_t;

    localparam ishp_pkg::bin_t LIM_CAP_V = ishp_pkg::bin_t'(LIM_CAP);
    localparam addr_t          LAST_ADDR = addr_t'(HIST_BINS - 1);
    localparam count_t         COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN,
        ST_SCAN
    } state_t;

    state_t               state_reg, state_next;
    ishp_pkg::bin_t       limit_reg, limit_next;
    addr_t                clr_addr_reg, clr_addr_next;
    logic                 s1_vld_reg, s1_vld_next;
    ishp_pkg::rec_t       s1_rec_reg, s1_rec_next;
    logic                 s2_vld_reg, s2_vld_next;
    ishp_pkg::bin_t       s2_bin_reg, s2_bin_next;
    logic                 fwd_vld_reg, fwd_vld_next;
    ishp_pkg::bin_t       fwd_bin_reg, fwd_bin_next;
    count_t               fwd_data_reg, fwd_data_next;
    ishp_pkg::bin_t       scan_cnt_reg, scan_cnt_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    ishp_pkg::bin_t       cmp_idx_reg, cmp_idx_next;
    count_t               best_reg, best_next;
    ishp_pkg::bin_t       peak_reg, peak_next;

    ishp_pkg::bin_t       eff_lim;
    ishp_pkg::bin_t       s1_bin;
    ishp_pkg::out_cnt_t   fifo_cnt;
    occ_t                 occ;
    logic                 in_acc;

    logic                 ram_we, ram_re;
    addr_t                ram_waddr, ram_raddr;
    count_t               ram_wdata, ram_rdata;
    count_t               s2_old, s2_new;

    logic                 push;
    ishp_pkg::result_t    push_data;
    ishp_pkg::result_t    out_data;

    assign eff_lim = (limit_reg > LIM_CAP_V) ? LIM_CAP_V : limit_reg;

    ishp_bin_calc u_bin_calc (
        .rec     (s1_rec_reg),
        .eff_lim (eff_lim),
        .bin     (s1_bin)
    );

    ishp_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (HIST_BINS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ishp_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (m_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .count     (fifo_cnt)
    );

    assign m_answer_kind = out_data.answer_kind;
    assign m_bin_index   = out_data.bin_index;

    assign occ     = occ_t'(fifo_cnt) + occ_t'(s1_vld_reg) + occ_t'(s2_vld_reg);
    assign s_ready = (state_reg == ST_RUN) && (occ < occ_t'(ishp_pkg::OUT_DEPTH));
    assign in_acc  = s_valid && s_ready;

    always_comb begin
        s2_old = (fwd_vld_reg && (fwd_bin_reg == s2_bin_reg)) ? fwd_data_reg : ram_rdata;
        s2_new = (s2_old == COUNT_MAX) ? s2_old : s2_old + count_t'(1);
    end

    always_comb begin
        state_next    = state_reg;
        limit_next    = cfg_wr_en ? cfg_wr_data : limit_reg;
        clr_addr_next = clr_addr_reg;
        scan_cnt_next = scan_cnt_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        best_next     = best_reg;
        peak_next     = peak_reg;

        s1_vld_next = in_acc && (s_opcode == ishp_pkg::OP_RECORD);
        s1_rec_next = s1_rec_reg;
        if (in_acc) begin
            s1_rec_next.overlapped         = s_overlapped;
            s1_rec_next.offset_positive    = s_offset_positive;
            s1_rec_next.overlap_length     = s_overlap_length;
            s1_rec_next.first_read_length  = s_first_read_length;
            s1_rec_next.second_read_length = s_second_read_length;
            s1_rec_next.first_front_trim   = s_first_front_trim;
            s1_rec_next.second_front_trim  = s_second_front_trim;
        end

        ram_re    = s1_vld_reg;
        ram_raddr = addr_t'(s1_bin);
        s2_vld_next = s1_vld_reg;
        s2_bin_next = s1_vld_reg ? s1_bin : s2_bin_reg;

        ram_we    = s2_vld_reg;
        ram_waddr = addr_t'(s2_bin_reg);
        ram_wdata = s2_new;
        push      = s2_vld_reg;
        push_data.answer_kind = ishp_pkg::KIND_RECORD;
        push_data.bin_index   = s2_bin_reg;

        fwd_vld_next  = s2_vld_reg;
        fwd_bin_next  = s2_bin_reg;
        fwd_data_next = s2_new;

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_RUN;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_RUN: begin
                if (in_acc && (s_opcode == ishp_pkg::OP_QUERY)) begin
                    state_next    = ST_DRAIN;
                    scan_cnt_next = '0;
                    cmp_vld_next  = 1'b0;
                    best_next     = '0;
                    peak_next     = '0;
                end
            end
            ST_DRAIN: begin
                if (!s1_vld_reg && !s2_vld_reg) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmp_vld_reg && (ram_rdata > best_reg)) begin
                    best_next = ram_rdata;
                    peak_next = cmp_idx_reg;
                end
                if (scan_cnt_reg < eff_lim) begin
                    ram_re        = 1'b1;
                    ram_raddr     = addr_t'(scan_cnt_reg);
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_cnt_reg;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end else begin
                    cmp_vld_next = 1'b0;
                    if (!cmp_vld_reg) begin
                        push                  = 1'b1;
                        push_data.answer_kind = ishp_pkg::KIND_PEAK;
                        push_data.bin_index   = peak_reg;
                        state_next            = ST_RUN;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            limit_reg    <= ishp_pkg::LIMIT_RESET;
            clr_addr_reg <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            fwd_vld_reg  <= 1'b0;
            cmp_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            limit_reg    <= limit_next;
            clr_addr_reg <= clr_addr_next;
            s1_vld_reg   <= s1_vld_next;
            s2_vld_reg   <= s2_vld_next;
            fwd_vld_reg  <= fwd_vld_next;
            cmp_vld_reg  <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_rec_reg   <= s1_rec_next;
        s2_bin_reg   <= s2_bin_next;
        fwd_bin_reg  <= fwd_bin_next;
        fwd_data_reg <= fwd_data_next;
        scan_cnt_reg <= scan_cnt_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_reg     <= best_next;
        peak_reg     <= peak_next;
    end

endmodule

// ----- src/ishp_checker.sv -----
`include "insert_size_histogram_peak_core_defines.svh"

module ishp_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           s_opcode,
    input logic           m_valid,
    input logic           m_ready,
    input logic           m_answer_kind,
    input ishp_pkg::bin_t m_bin_index
);

    // reset holds off input and empties the result queue
    `ISHP_ASSERT_NEXT_NORST(a_reset_quiet, aclk, !aresetn, !s_ready && !m_valid)

    // a stalled result item stays put
    `ISHP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_answer_kind) && $stable(m_bin_index))

    // a peak query closes the input until its scan is done
    `ISHP_ASSERT_NEXT(a_query_blocks, aclk, aresetn, s_valid && s_ready && (s_opcode == ishp_pkg::OP_QUERY), !s_ready)

endmodule

bind insert_size_histogram_peak_core ishp_checker u_ishp_checker (.*);
